### hdl/hrlp_pkg.sv
// hrlp_pkg: shared types, codes and character tables of the request line parser
// no dependencies; imported by every hrlp module and the top level
package hrlp_pkg;

   localparam int unsigned MaxRequestBytes = 65536;
   localparam int unsigned PosWidth = $clog2(MaxRequestBytes + 1);
   localparam logic [15:0] Sat16 = 16'hFFFF;

   typedef enum logic [1:0] {PH_METHOD, PH_PATH, PH_REST, PH_BAD} phase_type;
   typedef enum logic [1:0] {EN_IDLE, EN_WORK, EN_SUM} engine_type;
   typedef enum logic [1:0] {OP_NONE, OP_SEG, OP_FLUSH} op_kind_type;
   typedef enum logic [1:0] {TAIL_NONE, TAIL_BYTE, TAIL_FLUSH} tail_type;
   typedef enum logic [1:0] {SEG_PATH, SEG_QUERY, SEG_FRAG} seg_type;
   typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_DIGIT, ESC_CHAR} esc_type;

   localparam logic [3:0] MTH_UNKNOWN = 4'd0;
   localparam logic [3:0] MTH_GET     = 4'd1;
   localparam logic [3:0] MTH_HEAD    = 4'd2;
   localparam logic [3:0] MTH_OPTIONS = 4'd7;
   localparam logic [3:0] MTH_TRACE   = 4'd9;

   localparam logic [1:0] RPL_FILE        = 2'd0;
   localparam logic [1:0] RPL_OPTIONS     = 2'd1;
   localparam logic [1:0] RPL_TRACE       = 2'd2;
   localparam logic [1:0] RPL_NOT_ALLOWED = 2'd3;

   localparam logic [1:0] ERR_OK     = 2'd0;
   localparam logic [1:0] ERR_METHOD = 2'd1;
   localparam logic [1:0] ERR_MARKER = 2'd2;

   localparam logic [3:0] MIME_OTHER = 4'd10;

   localparam logic KIND_PATH    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] CSR_WINDOWS_PATHS   = 2'd0;
   localparam logic [1:0] CSR_START_PAGE_MIME = 2'd1;

   localparam logic [7:0] ChCr = 8'h0D;
   localparam logic [7:0] ChLf = 8'h0A;

   localparam logic [7:0] MthName [10][8] = '{
      '{"U", "N", "K", "N", "O", "W", "N", 8'h00},
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
      '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
      '{"C", "O", "N", "N", "E", "C", "T", 8'h00},
      '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00}};
   localparam logic [3:0] MthLen [10] = '{4'd7, 4'd3, 4'd4, 4'd4, 4'd3, 4'd5, 4'd6, 4'd7,
                                          4'd7, 4'd5};

   localparam logic [7:0] Marker [6] = '{" ", "H", "T", "T", "P", "/"};

   localparam logic [7:0] KaUp [22] = '{"C", "o", "n", "n", "e", "c", "t", "i", "o", "n",
      ":", " ", "K", "e", "e", "p", "-", "A", "l", "i", "v", "e"};
   localparam logic [7:0] KaLo [22] = '{"C", "o", "n", "n", "e", "c", "t", "i", "o", "n",
      ":", " ", "k", "e", "e", "p", "-", "a", "l", "i", "v", "e"};

   localparam logic [7:0] ExtName [12][4] = '{
      '{"h", "t", "m", "l"}, '{"h", "t", "m", 8'h00}, '{"c", "s", "s", 8'h00},
      '{"j", "s", 8'h00, 8'h00}, '{"t", "x", "t", 8'h00}, '{"j", "p", "g", 8'h00},
      '{"j", "p", "e", "g"}, '{"p", "n", "g", 8'h00}, '{"g", "i", "f", 8'h00},
      '{"s", "v", "g", 8'h00}, '{"j", "s", "o", "n"}, '{"x", "m", "l", 8'h00}};
   localparam logic [2:0] ExtLen [12] = '{3'd4, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4, 3'd3,
                                          3'd3, 3'd3, 3'd4, 3'd3};
   localparam logic [3:0] ExtCls [12] = '{4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5,
                                          4'd6, 4'd7, 4'd8, 4'd9};

   typedef struct packed {
      logic        go;
      op_kind_type kind;
      logic [7:0]  data;
   } hrlp_op_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] ch;
      logic       consume;
   } hrlp_dec_type;

   typedef struct packed {
      logic [15:0] plen;
      logic [15:0] qlen;
      logic [15:0] flen;
      logic [3:0]  mime;
   } hrlp_seg_type;

   typedef struct packed {
      logic [15:0] hdr_len;
      logic        keep;
   } hrlp_trk_type;

   function automatic logic [15:0] inc_sat(input logic [15:0] v);
      return (v == Sat16) ? v : v + 16'd1;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c >= "a") v = c - 8'd87;
      else if (c >= "A") v = c - 8'd55;
      else v = c - 8'd48;
      return v[3:0];
   endfunction

   function automatic logic [3:0] mime_lookup(input logic [31:0] ext, input logic [2:0] len);
      logic [3:0] cls;
      logic       hit;
      logic       found;
      cls = MIME_OTHER;
      found = 1'b0;
      for (int i = 0; i < 12; i++) begin
         hit = (len == ExtLen[i]);
         for (int j = 0; j < 4; j++) begin
            if (j < int'(len) && ext[8*j +: 8] != ExtName[i][j]) hit = 1'b0;
         end
         if (hit && !found) begin
            found = 1'b1;
            cls = ExtCls[i];
         end
      end
      return cls;
   endfunction

endpackage

### hdl/http_request_line_parser.sv
// http_request_line_parser: top level, one request byte per item
// a byte goes through the input register, then the result register, to its first path item;
//   the summary is loaded from the EN_SUM state into the result register after the last op
// throughput: 1 byte per cycle while the output is free; the engine stays busy while it replays
//   the bytes of a broken " HTTP/" match, passes through a broken escape, and sends the summary
// reset: synchronous, clears config, per-request state and both handshake registers
module http_request_line_parser import hrlp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_request_byte,
   input  logic        req_end_of_request,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_path_char,
   output logic [3:0]  rsp_method_code,
   output logic [1:0]  rsp_reply_kind,
   output logic [15:0] rsp_path_length,
   output logic [15:0] rsp_query_length,
   output logic [15:0] rsp_fragment_length,
   output logic [15:0] rsp_header_length,
   output logic [3:0]  rsp_mime_class,
   output logic        rsp_keep_alive,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);

   // configuration
   logic       win_ff;
   logic [3:0] start_ff;

   // input item register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // request line state
   phase_type          phase_ff, phase_in;
   logic [9:0]         mm_ff, mm_in;
   logic [3:0]         mpos_ff, mpos_in;
   logic [3:0]         mcode_ff, mcode_in;
   logic [2:0]         mk_ff, mk_in;
   logic [PosWidth-1:0] pos_ff, pos_in;

   // engine and pending work of the current item
   engine_type state_ff, state_in;
   logic [2:0] wk_idx_ff;
   logic [2:0] wk_len_ff;
   tail_type   wk_tail_ff;
   logic [7:0] wk_byte_ff;
   logic       wk_sup_ff;
   logic       wk_end_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff;
   logic [7:0]  char_ff;
   logic [3:0]  method_ff;
   logic [1:0]  reply_ff;
   logic [15:0] plen_ff, qlen_ff, flen_ff, hlen_ff;
   logic [3:0]  mime_ff;
   logic        keep_ff;
   logic [1:0]  err_ff;
   logic        last_ff;

   logic         live;
   logic         found;
   logic [3:0]   sel;
   logic [2:0]   ent_len;
   tail_type     ent_tail;
   logic         ent_sup;
   logic         busy;
   logic [2:0]   cur_idx;
   logic [2:0]   cur_len;
   tail_type     cur_tail;
   logic [7:0]   cur_byte;
   logic         cur_sup;
   logic         cur_end;
   logic         is_rep;
   logic         out_free;
   logic         go;
   logic         take;
   logic         step_done;
   logic [2:0]   idx_next;
   logic         clear_req;
   logic         path_emit;
   logic         bad;
   logic [1:0]   sum_reply;
   hrlp_op_type  op;
   hrlp_dec_type dec;
   hrlp_seg_type seg;
   hrlp_trk_type trk;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= 1'b0;
         start_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOWS_PATHS:   win_ff <= csr_data[0];
            CSR_START_PAGE_MIME: start_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // bytes past the size limit still close the request but are not parsed
   assign live = pos_ff < PosWidth'(MaxRequestBytes);

   // method match, marker match and the work list of the byte in the input register
   always_comb begin
      found    = 1'b0;
      sel      = MTH_UNKNOWN;
      mm_in    = mm_ff;
      mpos_in  = mpos_ff;
      mcode_in = mcode_ff;
      phase_in = phase_ff;
      mk_in    = mk_ff;
      pos_in   = pos_ff;
      ent_len  = '0;
      ent_tail = TAIL_NONE;
      if (live) begin
         pos_in = pos_ff + 1'b1;
         case (phase_ff)
            PH_METHOD: begin
               if (in_byte_ff == " ") begin
                  for (int i = 0; i < 10; i++) begin
                     if (!found && mm_ff[i] && MthLen[i] == mpos_ff) begin
                        found = 1'b1;
                        sel = 4'(i);
                     end
                  end
                  if (found && sel != MTH_UNKNOWN) begin
                     mcode_in = sel;
                     phase_in = PH_PATH;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end else begin
                  for (int i = 0; i < 10; i++) begin
                     if (mpos_ff >= MthLen[i] || MthName[i][mpos_ff[2:0]] != in_byte_ff)
                        mm_in[i] = 1'b0;
                  end
                  if (mpos_ff < 4'd8) mpos_in = mpos_ff + 4'd1;
                  if (mm_in == '0) phase_in = PH_BAD;
               end
            end
            PH_PATH: begin
               if (in_byte_ff == Marker[mk_ff]) begin
                  mk_in = mk_ff + 3'd1;
                  if (mk_ff == 3'd5) begin
                     phase_in = PH_REST;
                     ent_tail = TAIL_FLUSH;
                  end
               end else begin
                  // a broken marker match hands its bytes back to the target
                  ent_len = mk_ff;
                  if (in_byte_ff == " ") begin
                     mk_in = 3'd1;
                  end else begin
                     mk_in = 3'd0;
                     ent_tail = TAIL_BYTE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // path items of a closing byte are dropped unless the marker has been found
   assign ent_sup = in_end_ff && (phase_in != PH_REST);

   // select the operation of this cycle: new item or pending work
   always_comb begin
      busy     = (state_ff == EN_WORK);
      cur_idx  = busy ? wk_idx_ff : 3'd0;
      cur_len  = busy ? wk_len_ff : ent_len;
      cur_tail = busy ? wk_tail_ff : ent_tail;
      cur_byte = busy ? wk_byte_ff : in_byte_ff;
      cur_sup  = busy ? wk_sup_ff : ent_sup;
      cur_end  = busy ? wk_end_ff : in_end_ff;
      is_rep   = cur_idx < cur_len;
      out_free = !rsp_valid_ff || rsp_ready;
      go       = out_free && (busy || (state_ff == EN_IDLE && in_valid_ff));
      take     = go && (state_ff == EN_IDLE);
      if (is_rep) op.kind = OP_SEG;
      else if (cur_tail == TAIL_BYTE) op.kind = OP_SEG;
      else if (cur_tail == TAIL_FLUSH) op.kind = OP_FLUSH;
      else op.kind = OP_NONE;
      op.data = is_rep ? Marker[cur_idx] : cur_byte;
      op.go   = go && (op.kind != OP_NONE);
      step_done = (op.kind == OP_NONE) ||
                  (dec.consume && (!is_rep ||
                   (cur_idx + 3'd1 == cur_len && cur_tail == TAIL_NONE)));
      idx_next  = (dec.consume && is_rep) ? cur_idx + 3'd1 : cur_idx;
      clear_req = (state_ff == EN_SUM) && out_free;
      path_emit = op.go && dec.emit && !cur_sup;
   end

   // engine state machine
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EN_IDLE: begin
            if (go) state_in = step_done ? (cur_end ? EN_SUM : EN_IDLE) : EN_WORK;
         end
         EN_WORK: begin
            if (go && step_done) state_in = cur_end ? EN_SUM : EN_IDLE;
         end
         EN_SUM: begin
            if (out_free) state_in = EN_IDLE;
         end
         default: state_in = EN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= EN_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (go && !step_done) begin
         wk_idx_ff  <= idx_next;
         wk_len_ff  <= cur_len;
         wk_tail_ff <= cur_tail;
         wk_byte_ff <= cur_byte;
         wk_sup_ff  <= cur_sup;
         wk_end_ff  <= cur_end;
      end
   end

   // input register: takes the next byte while the engine works on this one
   assign req_ready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (take) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_request_byte;
         in_end_ff  <= req_end_of_request;
      end
   end

   // request line state, cleared when the summary leaves
   always_ff @(posedge clock) begin
      if (reset || clear_req) begin
         phase_ff <= PH_METHOD;
         mm_ff    <= '1;
         mpos_ff  <= '0;
         mcode_ff <= MTH_UNKNOWN;
         mk_ff    <= '0;
         pos_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         mm_ff    <= mm_in;
         mpos_ff  <= mpos_in;
         mcode_ff <= mcode_in;
         mk_ff    <= mk_in;
         pos_ff   <= pos_in;
      end
   end

   hrlp_track u_track (
      .clock (clock),
      .reset (reset),
      .en    (take && live),
      .clear (clear_req),
      .data  (in_byte_ff),
      .trk   (trk)
   );

   hrlp_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .clear      (clear_req),
      .windows    (win_ff),
      .start_mime (start_ff),
      .dec        (dec),
      .seg        (seg)
   );

   // summary fields
   always_comb begin
      bad = (phase_ff == PH_METHOD) || (phase_ff == PH_BAD);
      if (bad) sum_reply = RPL_NOT_ALLOWED;
      else if (mcode_ff == MTH_GET || mcode_ff == MTH_HEAD) sum_reply = RPL_FILE;
      else if (mcode_ff == MTH_OPTIONS) sum_reply = RPL_OPTIONS;
      else if (mcode_ff == MTH_TRACE) sum_reply = RPL_TRACE;
      else sum_reply = RPL_NOT_ALLOWED;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (path_emit || clear_req) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (path_emit) begin
         kind_ff   <= KIND_PATH;
         char_ff   <= dec.ch;
         method_ff <= '0;
         reply_ff  <= '0;
         plen_ff   <= '0;
         qlen_ff   <= '0;
         flen_ff   <= '0;
         hlen_ff   <= '0;
         mime_ff   <= '0;
         keep_ff   <= 1'b0;
         err_ff    <= ERR_OK;
         last_ff   <= 1'b0;
      end else if (clear_req) begin
         kind_ff   <= KIND_SUMMARY;
         char_ff   <= '0;
         method_ff <= bad ? MTH_UNKNOWN : mcode_ff;
         reply_ff  <= sum_reply;
         plen_ff   <= (phase_ff == PH_REST) ? seg.plen : 16'd0;
         qlen_ff   <= (phase_ff == PH_REST) ? seg.qlen : 16'd0;
         flen_ff   <= (phase_ff == PH_REST) ? seg.flen : 16'd0;
         hlen_ff   <= bad ? 16'd0 : trk.hdr_len;
         mime_ff   <= (phase_ff == PH_REST) ? seg.mime : MIME_OTHER;
         keep_ff   <= bad ? 1'b0 : trk.keep;
         err_ff    <= bad ? ERR_METHOD : ((phase_ff == PH_REST) ? ERR_OK : ERR_MARKER);
         last_ff   <= 1'b1;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_path_char       = char_ff;
   assign rsp_method_code     = method_ff;
   assign rsp_reply_kind      = reply_ff;
   assign rsp_path_length     = plen_ff;
   assign rsp_query_length    = qlen_ff;
   assign rsp_fragment_length = flen_ff;
   assign rsp_header_length   = hlen_ff;
   assign rsp_mime_class      = mime_ff;
   assign rsp_keep_alive      = keep_ff;
   assign rsp_error_code      = err_ff;
   assign rsp_last            = last_ff;

   // sending the summary returns the request state to its start
   a_clear: assert property (@(posedge clock) disable iff (reset)
      clear_req |=> (phase_ff == PH_METHOD && pos_ff == '0 && mk_ff == '0))
      else $error("request state not cleared after summary");

   // pending replay never runs past its marker bytes
   a_work_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EN_WORK) |-> (wk_idx_ff <= wk_len_ff && wk_len_ff < 3'd6))
      else $error("work pointer out of range");

   // while looking for the marker the match position stays below its length
   a_marker: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PATH) |-> (mk_ff < 3'd6))
      else $error("marker position out of range");

   // no byte is taken while the summary is pending
   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EN_SUM) |-> !take)
      else $error("byte taken during summary");

endmodule

### hdl/hrlp_track.sv
// hrlp_track: header section length and keep-alive header tracker
// depends on hrlp_pkg
module hrlp_track import hrlp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         clear,
   input  logic [7:0]   data,
   output hrlp_trk_type trk
);

   logic [23:0] lb_ff, lb_in;
   logic        crlf_ff, crlf_in;
   logic        done_ff, done_in;
   logic [15:0] hdr_ff, hdr_in;
   logic [4:0]  up_ff, up_in;
   logic [4:0]  lo_ff, lo_in;
   logic        flag_ff, flag_in;

   always_comb begin
      crlf_in = crlf_ff;
      done_in = done_ff;
      hdr_in  = hdr_ff;
      flag_in = flag_ff;
      if (crlf_ff && !done_ff) hdr_in = inc_sat(hdr_ff);
      if (lb_ff[7:0] == ChCr && data == ChLf) begin
         if (!crlf_ff) begin
            crlf_in = 1'b1;
            hdr_in  = 16'd2;
         end else if (!done_ff && lb_ff[15:8] == ChLf && lb_ff[23:16] == ChCr) begin
            done_in = 1'b1;
         end
      end
      // two pattern trackers, one per spelling
      if (up_ff < 5'd22 && data == KaUp[up_ff]) up_in = up_ff + 5'd1;
      else up_in = (data == "C") ? 5'd1 : 5'd0;
      if (lo_ff < 5'd22 && data == KaLo[lo_ff]) lo_in = lo_ff + 5'd1;
      else lo_in = (data == "C") ? 5'd1 : 5'd0;
      if (up_in == 5'd22 || lo_in == 5'd22) begin
         if (crlf_in && !done_in) flag_in = 1'b1;
         up_in = 5'd0;
         lo_in = 5'd0;
      end
      lb_in = {lb_ff[15:0], data};
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         lb_ff   <= '0;
         crlf_ff <= 1'b0;
         done_ff <= 1'b0;
         hdr_ff  <= '0;
         up_ff   <= '0;
         lo_ff   <= '0;
         flag_ff <= 1'b0;
      end else if (en) begin
         lb_ff   <= lb_in;
         crlf_ff <= crlf_in;
         done_ff <= done_in;
         hdr_ff  <= hdr_in;
         up_ff   <= up_in;
         lo_ff   <= lo_in;
         flag_ff <= flag_in;
      end
   end

   assign trk.hdr_len = done_ff ? hdr_ff : 16'd0;
   assign trk.keep    = flag_ff && done_ff;

endmodule

### hdl/hrlp_decode.sv
// hrlp_decode: target splitter, percent decoder and extension capture
// depends on hrlp_pkg; one target byte or flush step per operation
module hrlp_decode import hrlp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  hrlp_op_type  op,
   input  logic         clear,
   input  logic         windows,
   input  logic [3:0]   start_mime,
   output hrlp_dec_type dec,
   output hrlp_seg_type seg
);

   seg_type     seg_ff, seg_in;
   logic [15:0] plen_ff, plen_in;
   logic [15:0] qlen_ff, qlen_in;
   logic [15:0] flen_ff, flen_in;
   logic        slash_ff, slash_in;
   esc_type     esc_ff, esc_in;
   logic [7:0]  echar_ff, echar_in;
   logic        any_ff, any_in;
   logic        dot_ff, dot_in;
   logic [2:0]  elen_ff, elen_in;
   logic [31:0] ebuf_ff, ebuf_in;

   logic [7:0] b;
   logic [7:0] raw;
   logic [7:0] d;
   logic       emit;
   logic       qh;
   logic       drop;
   logic       cont;

   always_comb begin
      b = op.data;
      seg_in = seg_ff;
      plen_in = plen_ff;
      qlen_in = qlen_ff;
      flen_in = flen_ff;
      slash_in = slash_ff;
      esc_in = esc_ff;
      echar_in = echar_ff;
      any_in = any_ff;
      dot_in = dot_ff;
      elen_in = elen_ff;
      ebuf_in = ebuf_ff;
      raw = b;
      emit = 1'b0;
      dec.consume = 1'b0;
      qh = (b == "?") || (b == "#");
      drop = (plen_ff == 16'd0) && (b == "/");
      cont = !qh && !drop && is_hex(b) && (esc_ff == ESC_PCT || esc_ff == ESC_DIGIT);
      if (op.go) begin
         case (op.kind)
            OP_SEG: begin
               case (seg_ff)
                  SEG_PATH: begin
                     if (esc_ff == ESC_CHAR) begin
                        emit = 1'b1;
                        raw = echar_ff;
                        esc_in = ESC_NONE;
                     end else if (esc_ff != ESC_NONE && !cont) begin
                        // broken escape: pass the percent sign, then the held digit if there is one
                        emit = 1'b1;
                        raw = "%";
                        esc_in = (esc_ff == ESC_DIGIT) ? ESC_CHAR : ESC_NONE;
                     end else begin
                        dec.consume = 1'b1;
                        if (b == "?") begin
                           seg_in = SEG_QUERY;
                           qlen_in = 16'd1;
                        end else if (b == "#") begin
                           seg_in = SEG_FRAG;
                           flen_in = 16'd1;
                        end else begin
                           plen_in = inc_sat(plen_ff);
                           if (drop) begin
                              slash_in = 1'b1;
                           end else begin
                              case (esc_ff)
                                 ESC_PCT: begin
                                    esc_in = ESC_DIGIT;
                                    echar_in = b;
                                 end
                                 ESC_DIGIT: begin
                                    emit = 1'b1;
                                    raw = {hex_val(echar_ff), hex_val(b)};
                                    esc_in = ESC_NONE;
                                 end
                                 default: begin
                                    if (b == "%") esc_in = ESC_PCT;
                                    else emit = 1'b1;
                                 end
                              endcase
                           end
                        end
                     end
                  end
                  SEG_QUERY: begin
                     dec.consume = 1'b1;
                     if (b == "#" && flen_ff == 16'd0) begin
                        seg_in = SEG_FRAG;
                        flen_in = 16'd1;
                     end else begin
                        qlen_in = inc_sat(qlen_ff);
                     end
                  end
                  default: begin
                     dec.consume = 1'b1;
                     if (b == "?" && qlen_ff == 16'd0) begin
                        seg_in = SEG_QUERY;
                        qlen_in = 16'd1;
                     end else begin
                        flen_in = inc_sat(flen_ff);
                     end
                  end
               endcase
            end
            OP_FLUSH: begin
               if (esc_ff == ESC_CHAR) begin
                  emit = 1'b1;
                  raw = echar_ff;
                  esc_in = ESC_NONE;
               end else if (esc_ff != ESC_NONE) begin
                  emit = 1'b1;
                  raw = "%";
                  esc_in = (esc_ff == ESC_DIGIT) ? ESC_CHAR : ESC_NONE;
               end else begin
                  dec.consume = 1'b1;
               end
            end
            default: ;
         endcase
      end
      d = (windows && raw == "/") ? "\\" : raw;
      if (emit) begin
         if (d == ".") begin
            dot_in = any_ff;
            elen_in = 3'd0;
         end else if (dot_ff) begin
            if (elen_ff < 3'd4) begin
               ebuf_in[8*elen_ff[1:0] +: 8] = (d >= "A" && d <= "Z") ? d + 8'd32 : d;
               elen_in = elen_ff + 3'd1;
            end else begin
               elen_in = 3'd5;
            end
         end
         any_in = 1'b1;
      end
      dec.emit = emit;
      dec.ch = d;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         seg_ff   <= SEG_PATH;
         plen_ff  <= '0;
         qlen_ff  <= '0;
         flen_ff  <= '0;
         slash_ff <= 1'b0;
         esc_ff   <= ESC_NONE;
         echar_ff <= '0;
         any_ff   <= 1'b0;
         dot_ff   <= 1'b0;
         elen_ff  <= '0;
         ebuf_ff  <= '0;
      end else begin
         seg_ff   <= seg_in;
         plen_ff  <= plen_in;
         qlen_ff  <= qlen_in;
         flen_ff  <= flen_in;
         slash_ff <= slash_in;
         esc_ff   <= esc_in;
         echar_ff <= echar_in;
         any_ff   <= any_in;
         dot_ff   <= dot_in;
         elen_ff  <= elen_in;
         ebuf_ff  <= ebuf_in;
      end
   end

   always_comb begin
      seg.plen = plen_ff;
      seg.qlen = qlen_ff;
      seg.flen = flen_ff;
      if (plen_ff == {15'd0, slash_ff}) seg.mime = (start_mime > MIME_OTHER) ? MIME_OTHER
                                                                           : start_mime;
      else if (!dot_ff || elen_ff == 3'd0 || elen_ff > 3'd4) seg.mime = MIME_OTHER;
      else seg.mime = mime_lookup(ebuf_ff, elen_ff);
   end

endmodule
